[design/bpfc_pkg.sv]
// Package for the blit pixel format converter: format codes, register
// indexes, shared structs and the pixel decode/encode functions.
// No dependencies.
`timescale 1ns / 1ps

package bpfc_pkg;

   // largest rectangle side in pixels
   localparam int MAX_DIM     = 4096;
   localparam int CNT_W       = $clog2(MAX_DIM + 1);
   localparam int QUEUE_DEPTH = 2;

   // pixel format codes
   localparam logic [3:0] FMT_RGB565   = 4'h8;
   localparam logic [3:0] FMT_ARGB1555 = 4'h9;
   localparam logic [3:0] FMT_ARGB4444 = 4'ha;
   localparam logic [3:0] FMT_ARGB8888 = 4'hf;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_PIXEL_FORMATS = 3'd0;
   localparam logic [2:0] REG_DEST_BASE     = 3'd1;
   localparam logic [2:0] REG_DEST_PITCH    = 3'd2;
   localparam logic [2:0] REG_BLIT_WIDTH    = 3'd3;
   localparam logic [2:0] REG_BLIT_HEIGHT   = 3'd4;
   localparam logic [2:0] REG_DEST_RIGHT    = 3'd5;
   localparam logic [2:0] REG_DEST_BOTTOM   = 3'd6;
   localparam logic [2:0] REG_MIRROR_MODE   = 3'd7;

   // configuration as seen by the datapath, plus the write strobe
   typedef struct packed {
      logic [3:0]  src_fmt;
      logic [3:0]  dst_fmt;
      logic [31:0] base;
      logic [15:0] pitch;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] right;
      logic [15:0] bottom;
      logic [1:0]  mirror;
      logic        wr;
   } bpfc_cfg_type;

   // one classified pixel on its way from front to back
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [31:0] argb;
      logic        last;
   } bpfc_item_type;

   // source pixel to ARGB32 with bit replication
   function automatic logic [31:0] decode_argb(input logic [3:0] fmt, input logic [31:0] px);
      logic [31:0] res;
      begin
         case (fmt)
            FMT_ARGB8888: res = px;
            FMT_RGB565: res = {8'hff, px[15:11], px[15:13], px[10:5], px[10:9],
                               px[4:0], px[4:2]};
            FMT_ARGB1555: res = {{8{px[15]}}, px[14:10], px[14:12], px[9:5], px[9:7],
                                 px[4:0], px[4:2]};
            FMT_ARGB4444: res = {px[15:12], px[15:12], px[11:8], px[11:8],
                                 px[7:4], px[7:4], px[3:0], px[3:0]};
            default: res = {16'h0, px[15:0]};
         endcase
         return res;
      end
   endfunction

   // ARGB32 to destination format, two-byte formats zero extended
   function automatic logic [31:0] encode_argb(input logic [3:0] fmt, input logic [31:0] c);
      logic [31:0] res;
      begin
         case (fmt)
            FMT_ARGB8888: res = c;
            FMT_RGB565:   res = {16'h0, c[23:19], c[15:10], c[7:3]};
            FMT_ARGB1555: res = {16'h0, (c[31:24] != 8'h0), c[23:19], c[15:11], c[7:3]};
            FMT_ARGB4444: res = {16'h0, c[31:28], c[23:20], c[15:12], c[7:4]};
            default:      res = {16'h0, c[15:0]};
         endcase
         return res;
      end
   endfunction

endpackage

[design/bpfc_front.sv]
// Front end: accepts source beats, checks geometry, tracks column/row,
// computes the destination x/y and decodes the pixel to ARGB32.
// Depends on bpfc_pkg.
`timescale 1ns / 1ps

module bpfc_front
   import bpfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  bpfc_cfg_type  cfg,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [31:0]   req_source_pixel,
   output logic          push_valid,
   output bpfc_item_type push_item,
   input  logic          queue_full
);

   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic             stage_valid_ff, stage_valid_in;
   bpfc_item_type    stage_item_ff, stage_item_in;

   logic             geom_ok, accept, push;
   logic [CNT_W-1:0] col, row;
   logic             col_last, row_last;
   logic [16:0]      x_lo, y_lo;

   // geometry check, all from configuration
   assign geom_ok = (cfg.width != 16'h0) && (cfg.height != 16'h0) &&
                    ({1'b0, cfg.width} <= 17'(MAX_DIM)) &&
                    ({1'b0, cfg.height} <= 17'(MAX_DIM)) &&
                    ({1'b0, cfg.right} + 17'd1 >= {1'b0, cfg.width}) &&
                    ({1'b0, cfg.bottom} + 17'd1 >= {1'b0, cfg.height});

   assign push      = stage_valid_ff && !queue_full;
   assign req_ready = !stage_valid_ff || !queue_full;
   assign accept    = req_valid && req_ready;

   // position, with a guard against a counter past the rectangle
   always_comb begin
      if ((17'(col_ff) >= {1'b0, cfg.width}) || (17'(row_ff) >= {1'b0, cfg.height})) begin
         col = '0;
         row = '0;
      end else begin
         col = col_ff;
         row = row_ff;
      end
   end

   assign col_last = (17'(col) + 17'd1) == {1'b0, cfg.width};
   assign row_last = (17'(row) + 17'd1) == {1'b0, cfg.height};
   assign x_lo     = {1'b0, cfg.right} + 17'd1 - {1'b0, cfg.width};
   assign y_lo     = {1'b0, cfg.bottom} + 17'd1 - {1'b0, cfg.height};

   // classify the beat into the stage register
   always_comb begin
      stage_item_in = stage_item_ff;
      stage_valid_in = push ? 1'b0 : stage_valid_ff;
      if (accept) begin
         stage_valid_in = geom_ok;
         stage_item_in.x = cfg.mirror[0] ? (cfg.right - 16'(col)) : (x_lo[15:0] + 16'(col));
         stage_item_in.y = cfg.mirror[1] ? (cfg.bottom - 16'(row)) : (y_lo[15:0] + 16'(row));
         stage_item_in.argb = decode_argb(cfg.src_fmt, req_source_pixel);
         stage_item_in.last = col_last && row_last;
      end
   end

   // column/row counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept && geom_ok) begin
         if (col_last && row_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_last) begin
            col_in = '0;
            row_in = row + CNT_W'(1);
         end else begin
            col_in = col + CNT_W'(1);
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

   assign push_valid = push;
   assign push_item  = stage_item_ff;

   // counters stay inside the rectangle while geometry is good
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      geom_ok |-> ({4'h0, col_ff} < 17'(cfg.width)) && ({4'h0, row_ff} < 17'(cfg.height)))
      else $error("column/row counter outside rectangle");

   // a register write restarts the blit
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg.wr |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters not cleared by register write");

endmodule

[design/bpfc_queue.sv]
// Short queue between the front and back ends.
// Depends on bpfc_pkg.
`timescale 1ns / 1ps

module bpfc_queue
   import bpfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  bpfc_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output bpfc_item_type head_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

   bpfc_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_Q'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_Q'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // no overflow, no underflow
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && !not_empty))
      else $error("queue pushed when full or popped when empty");

endmodule

[design/bpfc_back.sv]
// Back end: pops classified pixels, forms the destination address,
// encodes the pixel and holds the result beat in the output register.
// Depends on bpfc_pkg.
`timescale 1ns / 1ps

module bpfc_back
   import bpfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  bpfc_cfg_type  cfg,
   input  logic          not_empty,
   input  bpfc_item_type head_item,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [31:0]   rsp_write_address,
   output logic [31:0]   rsp_write_data,
   output logic          rsp_write_four_bytes,
   output logic          rsp_last_of_blit
);

   logic        valid_ff, valid_in;
   logic [31:0] addr_ff, addr_in, data_ff, data_in;
   logic        four_ff, four_in, last_ff, last_in;

   logic        four;
   logic [31:0] row_off;
   logic [17:0] col_off;

   assign pop     = not_empty && (!valid_ff || rsp_ready);
   assign four    = (cfg.dst_fmt == FMT_ARGB8888);
   assign row_off = 32'(head_item.y) * 32'(cfg.pitch);
   assign col_off = four ? {head_item.x, 2'b00} : {1'b0, head_item.x, 1'b0};

   // output register load
   always_comb begin
      valid_in = (valid_ff && !rsp_ready) || pop;
      addr_in  = addr_ff;
      data_in  = data_ff;
      four_in  = four_ff;
      last_in  = last_ff;
      if (pop) begin
         addr_in = cfg.base + row_off + 32'(col_off);
         data_in = encode_argb(cfg.dst_fmt, head_item.argb);
         four_in = four;
         last_in = head_item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      addr_ff <= addr_in;
      data_ff <= data_in;
      four_ff <= four_in;
      last_ff <= last_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_write_address    = addr_ff;
   assign rsp_write_data       = data_ff;
   assign rsp_write_four_bytes = four_ff;
   assign rsp_last_of_blit     = last_ff;

   // two-byte writes carry nothing in the upper half
   a_half_clean: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !four_ff) |-> (data_ff[31:16] == 16'h0))
      else $error("two-byte write with nonzero upper half");

endmodule

[design/blit_pixel_format_converter_unit.sv]
// Pixel format converter for the destination side of a 2D blit.
// Holds the register file and joins front end, queue and back end.
// Depends on bpfc_pkg, bpfc_front, bpfc_queue, bpfc_back.
//
// Usage: program the registers over the csr_ port (4-byte spaced, any
// write restarts the blit at the top-left), then stream source pixels in
// row-major order on req_. Each accepted beat with good geometry yields one
// rsp_ beat with the destination byte address, converted data, write size
// and an end-of-rectangle flag; with bad geometry beats are taken and dropped.
// Each beat passes the front stage register, the queue and the output
// register on its way to rsp_valid. Throughput is one pixel per cycle while
// the receiver does not stall, set by the front stage, the 2-entry queue and
// the output register of the back end (one 16x16 multiply for the row offset).
// The receiver may stall at will: the output register holds its beat, the
// queue absorbs in-flight pixels and req_ready drops once the queue is full
// and the front stage holds a beat.
// Reset clears registers, counters, the queue and all valid flags.
`timescale 1ns / 1ps

module blit_pixel_format_converter_unit
   import bpfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_source_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_write_address,
   output logic [31:0] rsp_write_data,
   output logic        rsp_write_four_bytes,
   output logic        rsp_last_of_blit
);

   logic [11:0] formats_ff, formats_in;
   logic [31:0] base_ff, base_in;
   logic [15:0] pitch_ff, pitch_in, width_ff, width_in, height_ff, height_in;
   logic [15:0] right_ff, right_in, bottom_ff, bottom_in;
   logic [1:0]  mirror_ff, mirror_in;

   logic          wr;
   logic [2:0]    reg_idx;
   bpfc_cfg_type  cfg;
   logic          push, full, pop, not_empty;
   bpfc_item_type push_item, head_item;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_comb begin
      formats_in = formats_ff;
      base_in    = base_ff;
      pitch_in   = pitch_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      right_in   = right_ff;
      bottom_in  = bottom_ff;
      mirror_in  = mirror_ff;
      if (wr) begin
         case (reg_idx)
            REG_PIXEL_FORMATS: formats_in = csr_pwdata[11:0];
            REG_DEST_BASE:     base_in    = csr_pwdata;
            REG_DEST_PITCH:    pitch_in   = csr_pwdata[15:0];
            REG_BLIT_WIDTH:    width_in   = csr_pwdata[15:0];
            REG_BLIT_HEIGHT:   height_in  = csr_pwdata[15:0];
            REG_DEST_RIGHT:    right_in   = csr_pwdata[15:0];
            REG_DEST_BOTTOM:   bottom_in  = csr_pwdata[15:0];
            REG_MIRROR_MODE:   mirror_in  = csr_pwdata[1:0];
            default:           formats_in = formats_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         formats_ff <= '0;
         base_ff    <= '0;
         pitch_ff   <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         right_ff   <= '0;
         bottom_ff  <= '0;
         mirror_ff  <= '0;
      end else begin
         formats_ff <= formats_in;
         base_ff    <= base_in;
         pitch_ff   <= pitch_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         right_ff   <= right_in;
         bottom_ff  <= bottom_in;
         mirror_ff  <= mirror_in;
      end
   end

   // register read
   always_comb begin
      case (reg_idx)
         REG_PIXEL_FORMATS: csr_prdata = {20'h0, formats_ff};
         REG_DEST_BASE:     csr_prdata = base_ff;
         REG_DEST_PITCH:    csr_prdata = {16'h0, pitch_ff};
         REG_BLIT_WIDTH:    csr_prdata = {16'h0, width_ff};
         REG_BLIT_HEIGHT:   csr_prdata = {16'h0, height_ff};
         REG_DEST_RIGHT:    csr_prdata = {16'h0, right_ff};
         REG_DEST_BOTTOM:   csr_prdata = {16'h0, bottom_ff};
         REG_MIRROR_MODE:   csr_prdata = {30'h0, mirror_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.src_fmt = formats_ff[3:0];
   assign cfg.dst_fmt = formats_ff[11:8];
   assign cfg.base    = base_ff;
   assign cfg.pitch   = pitch_ff;
   assign cfg.width   = width_ff;
   assign cfg.height  = height_ff;
   assign cfg.right   = right_ff;
   assign cfg.bottom  = bottom_ff;
   assign cfg.mirror  = mirror_ff;
   assign cfg.wr      = wr;

   bpfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source_pixel (req_source_pixel),
      .push_valid       (push),
      .push_item        (push_item),
      .queue_full       (full)
   );

   bpfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   bpfc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .not_empty            (not_empty),
      .head_item            (head_item),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_write_address    (rsp_write_address),
      .rsp_write_data       (rsp_write_data),
      .rsp_write_four_bytes (rsp_write_four_bytes),
      .rsp_last_of_blit     (rsp_last_of_blit)
   );

endmodule

[sim/tb.sv]
// Self-checking testbench for blit_pixel_format_converter_unit: drives pixel
// beats and CSR writes, predicts each destination write and checks rsp_ beats.
// Depends on bpfc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb;
   import bpfc_pkg::*;

   // one expected or observed destination write
   typedef struct packed {
      logic [31:0] address;
      logic [31:0] data;
      logic        four_bytes;
      logic        last;
   } write_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_source_pixel = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_write_address;
   logic [31:0] rsp_write_data;
   logic        rsp_write_four_bytes;
   logic        rsp_last_of_blit;

   blit_pixel_format_converter_unit dut (.*);

   always #2 clock = ~clock;

   // shadow of the register file and the raster position
   logic [11:0] fmt_reg;
   logic [31:0] base_reg;
   logic [15:0] pitch_reg, width_reg, height_reg, right_reg, bottom_reg;
   logic [1:0]  mirror_reg;
   logic [12:0] col_cnt, row_cnt;

   logic [31:0]    pixel_q[$];
   write_beat_type write_q[$];
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   bit             req_took = 1'b0;
   int             mismatch_cnt = 0;
   int             fail_cnt = 0;

   function automatic void apply_csr(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
         REG_PIXEL_FORMATS: fmt_reg = val[11:0];
         REG_DEST_BASE:     base_reg = val;
         REG_DEST_PITCH:    pitch_reg = val[15:0];
         REG_BLIT_WIDTH:    width_reg = val[15:0];
         REG_BLIT_HEIGHT:   height_reg = val[15:0];
         REG_DEST_RIGHT:    right_reg = val[15:0];
         REG_DEST_BOTTOM:   bottom_reg = val[15:0];
         REG_MIRROR_MODE:   mirror_reg = val[1:0];
         default: ;
      endcase
      col_cnt = '0;
      row_cnt = '0;
   endfunction

   function automatic bit geometry_ok();
      return width_reg != 0 && height_reg != 0 &&
             width_reg <= MAX_DIM && height_reg <= MAX_DIM &&
             int'(right_reg) + 1 >= int'(width_reg) &&
             int'(bottom_reg) + 1 >= int'(height_reg);
   endfunction

   // source pixel to ARGB32, low bits refilled from the top of each channel
   function automatic logic [31:0] expand_to_argb(input logic [3:0] fmt, input logic [31:0] px);
      logic [4:0] r5, g5, b5;
      logic [5:0] g6;
      r5 = px[14:10];
      g5 = px[9:5];
      b5 = px[4:0];
      g6 = px[10:5];
      case (fmt)
         FMT_ARGB8888: return px;
         FMT_RGB565:
            return {8'hff, px[15:11], px[15:13], g6, g6[5:4], b5, b5[4:2]};
         FMT_ARGB1555:
            return {px[15] ? 8'hff : 8'h00, r5, r5[4:2], g5, g5[4:2], b5, b5[4:2]};
         FMT_ARGB4444:
            return {8'(px[15:12] * 8'h11), 8'(px[11:8] * 8'h11),
                    8'(px[7:4] * 8'h11), 8'(px[3:0] * 8'h11)};
         default: return {16'h0, px[15:0]};
      endcase
   endfunction

   // ARGB32 to the destination layout by truncating each channel (ARGB1555 alpha: any nonzero)
   function automatic logic [31:0] pack_from_argb(input logic [3:0] fmt, input logic [31:0] c);
      logic [7:0] a, r, g, b;
      {a, r, g, b} = c;
      case (fmt)
         FMT_ARGB8888: return c;
         FMT_RGB565:   return {16'h0, r[7:3], g[7:2], b[7:3]};
         FMT_ARGB1555: return {16'h0, a != 8'h0, r[7:3], g[7:3], b[7:3]};
         FMT_ARGB4444: return {16'h0, a[7:4], r[7:4], g[7:4], b[7:4]};
         default:      return {16'h0, c[15:0]};
      endcase
   endfunction

   // destination write for one source pixel; advances the raster position
   function automatic bit predict_write(input logic [31:0] src_px,
                                        output write_beat_type beat);
      logic [31:0] col, row, x, y, bpp;
      beat = '0;
      if (!geometry_ok())
         return 1'b0;
      col = col_cnt;
      row = row_cnt;
      if (col >= width_reg || row >= height_reg) begin
         col = 0;
         row = 0;
      end
      x = mirror_reg[0] ? right_reg - col : right_reg + 1 - width_reg + col;
      y = mirror_reg[1] ? bottom_reg - row : bottom_reg + 1 - height_reg + row;
      bpp = (fmt_reg[11:8] == FMT_ARGB8888) ? 4 : 2;
      beat.data = pack_from_argb(fmt_reg[11:8], expand_to_argb(fmt_reg[3:0], src_px));
      if (bpp == 2)
         beat.data[31:16] = '0;
      beat.address = base_reg + y * pitch_reg + x * bpp;
      beat.four_bytes = (bpp == 4);
      beat.last = (col + 1 == width_reg) && (row + 1 == height_reg);
      if (beat.last) begin
         col_cnt = '0;
         row_cnt = '0;
      end else if (col + 1 == width_reg) begin
         col_cnt = '0;
         row_cnt = 13'(row + 1);
      end else begin
         col_cnt = 13'(col + 1);
         row_cnt = 13'(row);
      end
      return 1'b1;
   endfunction

   // driver: pixel beats from pixel_q, random sender gaps and receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_source_pixel <= pixel_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // monitor: predict on each accepted pixel, check each accepted write
   always @(posedge clock) begin : monitor
      write_beat_type exp_beat, got_beat;
      req_took = !reset && req_valid && req_ready;
      if (req_took && predict_write(req_source_pixel, exp_beat))
         write_q.push_back(exp_beat);
      if (!reset && rsp_valid && rsp_ready) begin
         got_beat = {rsp_write_address, rsp_write_data, rsp_write_four_bytes,
                     rsp_last_of_blit};
         if (write_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected write beat: addr %h data %h four %0d last %0d",
                        got_beat.address, got_beat.data, got_beat.four_bytes,
                        got_beat.last);
         end else begin
            exp_beat = write_q.pop_front();
            if (got_beat !== exp_beat) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch exp %h %h %0d %0d got %h %h %0d %0d",
                           exp_beat.address, exp_beat.data, exp_beat.four_bytes,
                           exp_beat.last, got_beat.address, got_beat.data,
                           got_beat.four_bytes, got_beat.last);
            end
         end
      end
   end

   // APB write: setup cycle, then access cycle
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      apply_csr(idx, val);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure_blit(input logic [11:0] fmt, input logic [31:0] base,
                                 input logic [15:0] pitch, input logic [15:0] w,
                                 input logic [15:0] h, input logic [15:0] right,
                                 input logic [15:0] bottom, input logic [1:0] mirror);
      write_csr(REG_PIXEL_FORMATS, {20'h0, fmt});
      write_csr(REG_DEST_BASE, base);
      write_csr(REG_DEST_PITCH, {16'h0, pitch});
      write_csr(REG_BLIT_WIDTH, {16'h0, w});
      write_csr(REG_BLIT_HEIGHT, {16'h0, h});
      write_csr(REG_DEST_RIGHT, {16'h0, right});
      write_csr(REG_DEST_BOTTOM, {16'h0, bottom});
      write_csr(REG_MIRROR_MODE, {30'h0, mirror});
   endtask

   // wait until every pixel is taken and every write has come back
   task automatic drain_writes();
      while (pixel_q.size() != 0 || req_valid || write_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [3:0] pick_format();
      case ($urandom_range(0, 4))
         0: return FMT_RGB565;
         1: return FMT_ARGB1555;
         2: return FMT_ARGB4444;
         3: return FMT_ARGB8888;
         default: return 4'($urandom_range(0, 15));
      endcase
   endfunction

   initial begin : stimulus
      int unsigned w, h, right, bottom, count, random_items, roll;
      logic [11:0] fmt;
      apply_csr(REG_PIXEL_FORMATS, '0);
      apply_csr(REG_DEST_BASE, '0);
      apply_csr(REG_DEST_PITCH, '0);
      apply_csr(REG_BLIT_WIDTH, '0);
      apply_csr(REG_BLIT_HEIGHT, '0);
      apply_csr(REG_DEST_RIGHT, '0);
      apply_csr(REG_DEST_BOTTOM, '0);
      apply_csr(REG_MIRROR_MODE, '0);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: each format on both sides, all mirror modes, channel extremes
      configure_blit({FMT_ARGB8888, 4'h0, FMT_RGB565}, 32'h1000_0000, 16'd64,
                     16'd2, 16'd2, 16'd9, 16'd5, 2'd0);
      pixel_q = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_f800, 32'h0000_001f};
      drain_writes();
      configure_blit({FMT_RGB565, 4'hf, FMT_ARGB8888}, 32'hffff_fff0, 16'd32,
                     16'd2, 16'd1, 16'd1, 16'd0, 2'd1);
      pixel_q = '{32'hffff_ffff, 32'h0000_0000};
      drain_writes();
      configure_blit({FMT_ARGB1555, 4'h0, FMT_ARGB1555}, 32'h0, 16'd100,
                     16'd1, 16'd2, 16'd0, 16'd7, 2'd2);
      pixel_q = '{32'h0000_8000, 32'hffff_7fff};
      drain_writes();
      configure_blit({FMT_ARGB4444, 4'h0, FMT_ARGB4444}, 32'h8000_0000, 16'hffff,
                     16'd2, 16'd2, 16'd65535, 16'd65535, 2'd3);
      pixel_q = '{32'h0000_0000, 32'h0000_ffff, 32'h0000_1234, 32'h0000_edcb};
      drain_writes();
      // unknown codes on both sides; the second pixel restarts the rectangle
      configure_blit(12'h300, 32'h0000_0100, 16'd4, 16'd1, 16'd1, 16'd3, 16'd3, 2'd0);
      pixel_q = '{32'hdead_beef, 32'hbeef_dead};
      drain_writes();
      // bad geometry: zero, oversized, and rectangle past the top-left
      configure_blit({FMT_ARGB8888, 4'h0, FMT_ARGB8888}, 32'h0, 16'd16,
                     16'd0, 16'd2, 16'd9, 16'd9, 2'd0);
      pixel_q = '{32'h1111_1111};
      drain_writes();
      write_csr(REG_BLIT_WIDTH, 32'd2);
      write_csr(REG_BLIT_HEIGHT, 32'd0);
      pixel_q = '{32'h2222_2222};
      drain_writes();
      write_csr(REG_BLIT_HEIGHT, 32'd4097);
      pixel_q = '{32'h3333_3333};
      drain_writes();
      configure_blit({FMT_ARGB8888, 4'h0, FMT_ARGB8888}, 32'h0, 16'd16,
                     16'd4097, 16'd1, 16'd65535, 16'd9, 2'd0);
      pixel_q = '{32'h4444_4444};
      drain_writes();
      configure_blit({FMT_ARGB8888, 4'h0, FMT_ARGB8888}, 32'h0, 16'd16,
                     16'd4, 16'd2, 16'd2, 16'd9, 2'd0);
      pixel_q = '{32'h5555_5555};
      drain_writes();
      // largest rectangle at the far corner, then a write mid-rectangle
      configure_blit({FMT_ARGB8888, 4'h0, FMT_ARGB1555}, 32'hffff_ffff, 16'hffff,
                     16'd4096, 16'd4096, 16'd65535, 16'd65535, 2'd0);
      pixel_q = '{32'h0000_8000, 32'h0000_7fff, 32'h0000_5555};
      drain_writes();
      write_csr(REG_MIRROR_MODE, 32'd3);
      pixel_q = '{32'h0000_aaaa};
      drain_writes();

      // random blits over four idling phases
      random_items = 0;
      while (random_items < 2000) begin
         case (random_items / 500)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // mostly bad geometry from unconstrained registers
            configure_blit(12'($urandom), $urandom, 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom));
            count = 3;
         end else begin
            w = (roll < 14) ? $urandom_range(1, MAX_DIM) : $urandom_range(1, 8);
            h = (roll < 14 || roll > 95) ? $urandom_range(1, MAX_DIM) : $urandom_range(1, 6);
            right = ($urandom_range(0, 9) == 0) ? 65535 : w - 1 + $urandom_range(0, 300);
            bottom = ($urandom_range(0, 9) == 0) ? 65535 : h - 1 + $urandom_range(0, 300);
            if (roll < 11 && w > 1)
               right = w - 2;
            fmt = {pick_format(), 4'($urandom), pick_format()};
            configure_blit(fmt, $urandom, 16'($urandom), 16'(w), 16'(h), 16'(right),
                           16'(bottom), 2'($urandom));
            if (w * h > 40)
               count = $urandom_range(1, 40);
            else if ($urandom_range(0, 4) == 0)
               count = $urandom_range(1, w * h + 3);
            else
               count = w * h;
         end
         repeat (count) pixel_q.push_back($urandom);
         if (geometry_ok())
            random_items += count;
         drain_writes();
      end

      repeat (20) @(posedge clock);
      fail_cnt = mismatch_cnt + write_q.size();
      if (fail_cnt == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
